### rtl/tick_bracket_position_manager_defines.svh
// Assertion helpers for the top-level RTL file. Each expects clk and arst_n in scope.
`ifndef TICK_BRACKET_POSITION_MANAGER_DEFINES_SVH
`define TICK_BRACKET_POSITION_MANAGER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TBPM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TBPM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tbpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbpm_pkg;

	// Field widths
	localparam int TIME_W     = 40;
	localparam int PRICE_W    = 31;
	localparam int VOL_W      = 32;
	localparam int DIST_W     = 20;
	localparam int TIMEOUT_W  = 32;
	localparam int WLEN_W     = 10;
	localparam int LEVEL_W    = 32;
	localparam int PROFIT_W   = 32;
	localparam int BAL_W      = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Register reset values
	localparam logic [DIST_W-1:0]    STOP_DIST_RST = 20'd20;
	localparam logic [DIST_W-1:0]    TAKE_DIST_RST = 20'd40;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 32'd4559000;
	localparam logic [VOL_W-1:0]     VOL_THR_RST   = 32'd100;
	localparam logic [DIST_W-1:0]    TREND_THR_RST = 20'd10;
	localparam logic [WLEN_W-1:0]    WLEN_RST      = 10'd500;
	localparam logic [DIST_W-1:0]    FEE_RST       = 20'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STOP_DISTANCE    = 3'd0,
		REG_TAKE_DISTANCE    = 3'd1,
		REG_HOLD_TIMEOUT     = 3'd2,
		REG_VOLUME_THRESHOLD = 3'd3,
		REG_TREND_THRESHOLD  = 3'd4,
		REG_WINDOW_LENGTH    = 3'd5,
		REG_TRADE_FEE        = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		OP_TICK   = 1'b0,
		OP_FINISH = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		REASON_STOP    = 2'd0,
		REASON_TAKE    = 2'd1,
		REASON_REVERSE = 2'd2,
		REASON_TIMEOUT = 2'd3
	} reason_t;

	// Entry signal from the price window to the position logic
	typedef struct packed {
		logic go_long;
		logic go_short;
	} trend_t;

endpackage

`default_nettype wire

### rtl/tbpm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tbpm_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/tbpm_window.sv
`timescale 1ns / 1ps
`default_nettype none

module tbpm_window #(
	parameter int MAX_WINDOW = 512
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic                          acc_tick,
	input  wire logic [tbpm_pkg::PRICE_W-1:0]  acc_price,
	input  wire logic                          step,
	input  wire logic [tbpm_pkg::PRICE_W-1:0]  price_s1,
	input  wire logic [tbpm_pkg::WLEN_W-1:0]   win_length,
	input  wire logic                          win_clear,
	input  wire logic [tbpm_pkg::DIST_W-1:0]   trend_thr,
	output tbpm_pkg::trend_t                   trend
);

	localparam int PW     = $clog2(MAX_WINDOW);
	localparam int CW     = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = tbpm_pkg::PRICE_W + CW;
	localparam int THRN_W = tbpm_pkg::DIST_W + CW;

	logic [CW-1:0]     win_w;
	logic [PW-1:0]     ptr_q;
	logic [CW-1:0]     fill_q;
	logic [PW-1:0]     slot;
	logic [CW-1:0]     slot_inc;
	logic              full;
	logic [SUM_W-1:0]  prod_next;
	logic [THRN_W-1:0] thrn_next;

	logic [PW-1:0]                  slot_s1;
	logic                           full_s1;
	logic                           nz_s1;
	logic [SUM_W-1:0]               prod_s1;
	logic [THRN_W-1:0]              thrn_s1;
	logic                           byp_s1;
	logic [tbpm_pkg::PRICE_W-1:0]   byp_data_s1;
	logic [tbpm_pkg::PRICE_W-1:0]   rd_data;
	logic [tbpm_pkg::PRICE_W-1:0]   old_price;
	logic [SUM_W-1:0]               sum_q;
	logic signed [SUM_W:0]          diff;
	logic [SUM_W:0]                 mag;
	logic                           neg;
	logic                           flat;

	// Clamp the window length to 1..MAX_WINDOW
	always_comb begin
		if (win_length == '0) begin
			win_w = CW'(1);
		end else if (32'(win_length) > MAX_WINDOW) begin
			win_w = CW'(MAX_WINDOW);
		end else begin
			win_w = CW'(win_length);
		end
	end

	// Slot for the next tick and the ring bookkeeping that follows it
	assign slot      = (CW'(ptr_q) < win_w) ? ptr_q : '0;
	assign slot_inc  = CW'(slot) + CW'(1);
	assign full      = fill_q >= win_w;
	assign prod_next = SUM_W'(acc_price) * SUM_W'(fill_q);
	assign thrn_next = THRN_W'(trend_thr) * THRN_W'(fill_q);

	// Advance pointer and fill count as ticks are taken in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (win_clear) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (accept && acc_tick) begin
			ptr_q  <= (slot_inc >= win_w) ? '0 : PW'(slot_inc);
			fill_q <= full ? fill_q : fill_q + CW'(1);
		end
	end

	// Stage one: products, slot and the forwarded price when the slot is written now
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1     <= slot;
			full_s1     <= full;
			nz_s1       <= fill_q != '0;
			prod_s1     <= prod_next;
			thrn_s1     <= thrn_next;
			byp_s1      <= step && (slot_s1 == slot);
			byp_data_s1 <= price_s1;
		end
	end

	tbpm_ram #(
		.WIDTH (tbpm_pkg::PRICE_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (step),
		.waddr (slot_s1),
		.wdata (price_s1),
		.re    (accept),
		.raddr (slot),
		.rdata (rd_data)
	);

	assign old_price = byp_s1 ? byp_data_s1 : rd_data;

	// Running sum: drop the oldest price once full, add the new one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (win_clear) begin
			sum_q <= '0;
		end else if (step) begin
			sum_q <= sum_q - (full_s1 ? SUM_W'(old_price) : '0) + SUM_W'(price_s1);
		end
	end

	// Compare sum against price times count, gap against threshold times count
	assign diff = $signed({1'b0, sum_q}) - $signed({1'b0, prod_s1});
	assign neg  = diff[SUM_W];
	assign mag  = neg ? $unsigned(-diff) : $unsigned(diff);
	assign flat = mag < (SUM_W + 1)'(thrn_s1);

	always_comb begin
		trend.go_long  = nz_s1 && (flat ? neg : !neg);
		trend.go_short = nz_s1 && (flat ? (!neg && (diff != '0)) : neg);
	end

endmodule

`default_nettype wire

### rtl/tick_bracket_position_manager.sv
`timescale 1ns / 1ps
`default_nettype none

// Tick bracket position manager. Takes one item per clock while the output is not
// stalled: a market tick or a finish command, and returns exactly one result beat per
// item. Throughput is one item per cycle under that condition; it is set by the position
// and running-sum update in stage one, where each item sees the state left by the one
// before. Recent prices sit in a MAX_WINDOW deep RAM, read when the item is taken in and
// written by stage one; the ring needs no clearing pass after reset since a fill count
// guards every read. Writing window_length empties the window. The configuration port is
// always ready; write registers only while no item is in flight.
`include "tick_bracket_position_manager_defines.svh"

module tick_bracket_position_manager #(
	parameter int MAX_WINDOW = 512
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              opcode,
	input  wire logic [tbpm_pkg::TIME_W-1:0]       tick_time,
	input  wire logic [tbpm_pkg::PRICE_W-1:0]      tick_price,
	input  wire logic [tbpm_pkg::VOL_W-1:0]        tick_volume,

	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   closed,
	output logic [1:0]                             close_reason,
	output logic signed [tbpm_pkg::PROFIT_W-1:0]   trade_profit,
	output logic signed [tbpm_pkg::BAL_W-1:0]      running_balance,
	output logic                                   opened,
	output logic                                   position_open,
	output logic                                   position_short,

	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tbpm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tbpm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// Configuration registers
	logic [tbpm_pkg::DIST_W-1:0]    stop_dist_q;
	logic [tbpm_pkg::DIST_W-1:0]    take_dist_q;
	logic [tbpm_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [tbpm_pkg::VOL_W-1:0]     vol_thr_q;
	logic [tbpm_pkg::DIST_W-1:0]    trend_thr_q;
	logic [tbpm_pkg::WLEN_W-1:0]    wlen_q;
	logic [tbpm_pkg::DIST_W-1:0]    fee_q;
	logic                           cfg_wr;

	// Handshake
	logic in_acc;
	logic fire1;

	// Stage one
	logic                           valid_s1;
	tbpm_pkg::opcode_t              op_s1;
	logic [tbpm_pkg::TIME_W-1:0]    time_s1;
	logic [tbpm_pkg::PRICE_W-1:0]   price_s1;
	logic                           vol_hit_s1;

	// Position state
	logic                           holding_q;
	logic                           short_q;
	logic [tbpm_pkg::PRICE_W-1:0]   entry_price_q;
	logic [tbpm_pkg::TIME_W-1:0]    entry_time_q;
	logic [tbpm_pkg::TIME_W:0]      deadline_q;
	logic [tbpm_pkg::LEVEL_W-1:0]   stop_q;
	logic [tbpm_pkg::LEVEL_W-1:0]   take_q;
	logic signed [tbpm_pkg::BAL_W-1:0] balance_q;

	// Result register
	logic                           out_valid_q;
	logic                           closed_q;
	tbpm_pkg::reason_t              reason_q;
	logic signed [tbpm_pkg::PROFIT_W-1:0] profit_q;
	logic                           opened_q;
	logic                           position_open_q;
	logic                           position_short_q;

	// Stage one decisions
	tbpm_pkg::trend_t               trend;
	logic                           is_tick;
	logic [tbpm_pkg::LEVEL_W-1:0]   p32;
	logic                           timeout_hit;
	logic                           stop_hit;
	logic                           take_hit;
	logic                           exit_close;
	tbpm_pkg::reason_t              exit_reason;
	logic                           still_held;
	logic                           want_signal;
	logic                           want_short;
	logic                           open_now;
	logic                           rev_close;
	logic                           close_now;
	tbpm_pkg::reason_t              reason_now;
	logic signed [tbpm_pkg::PRICE_W+1:0] diff_gain;
	logic signed [tbpm_pkg::PRICE_W+2:0] gain_raw;
	logic signed [tbpm_pkg::PROFIT_W-1:0] gain_sat;
	logic signed [tbpm_pkg::BAL_W:0]     bal_sum;
	logic signed [tbpm_pkg::BAL_W-1:0]   bal_next;
	logic                           hold_next;
	logic                           short_next;
	logic [tbpm_pkg::LEVEL_W-1:0]   stop_open;
	logic [tbpm_pkg::LEVEL_W-1:0]   take_open;

	// Configuration writes
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_dist_q <= tbpm_pkg::STOP_DIST_RST;
			take_dist_q <= tbpm_pkg::TAKE_DIST_RST;
			timeout_q   <= tbpm_pkg::TIMEOUT_RST;
			vol_thr_q   <= tbpm_pkg::VOL_THR_RST;
			trend_thr_q <= tbpm_pkg::TREND_THR_RST;
			wlen_q      <= tbpm_pkg::WLEN_RST;
			fee_q       <= tbpm_pkg::FEE_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				tbpm_pkg::REG_STOP_DISTANCE:    stop_dist_q <= cfg_data[tbpm_pkg::DIST_W-1:0];
				tbpm_pkg::REG_TAKE_DISTANCE:    take_dist_q <= cfg_data[tbpm_pkg::DIST_W-1:0];
				tbpm_pkg::REG_HOLD_TIMEOUT:     timeout_q   <= cfg_data[tbpm_pkg::TIMEOUT_W-1:0];
				tbpm_pkg::REG_VOLUME_THRESHOLD: vol_thr_q   <= cfg_data[tbpm_pkg::VOL_W-1:0];
				tbpm_pkg::REG_TREND_THRESHOLD:  trend_thr_q <= cfg_data[tbpm_pkg::DIST_W-1:0];
				tbpm_pkg::REG_WINDOW_LENGTH:    wlen_q      <= cfg_data[tbpm_pkg::WLEN_W-1:0];
				tbpm_pkg::REG_TRADE_FEE:        fee_q       <= cfg_data[tbpm_pkg::DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage one advances whenever the result register is free or being drained
	assign fire1    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire1;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1      <= tbpm_pkg::opcode_t'(opcode);
			time_s1    <= tick_time;
			price_s1   <= tick_price;
			vol_hit_s1 <= tick_volume > vol_thr_q;
		end
	end

	tbpm_window #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_acc),
		.acc_tick   (opcode == tbpm_pkg::OP_TICK),
		.acc_price  (tick_price),
		.step       (fire1 && (op_s1 == tbpm_pkg::OP_TICK)),
		.price_s1   (price_s1),
		.win_length (wlen_q),
		.win_clear  (cfg_wr && (cfg_index == tbpm_pkg::REG_WINDOW_LENGTH)),
		.trend_thr  (trend_thr_q),
		.trend      (trend)
	);

	// Exit checks: timeout first, then stop, then take; finish always closes a held position
	always_comb begin
		is_tick     = op_s1 == tbpm_pkg::OP_TICK;
		p32         = {1'b0, price_s1};
		timeout_hit = {1'b0, time_s1} >= deadline_q;
		stop_hit    = short_q ? (p32 > stop_q) : (p32 < stop_q);
		take_hit    = short_q ? (p32 < take_q) : (p32 > take_q);
		exit_close  = 1'b0;
		exit_reason = tbpm_pkg::REASON_TIMEOUT;
		if (holding_q) begin
			if (!is_tick || timeout_hit) begin
				exit_close  = 1'b1;
				exit_reason = tbpm_pkg::REASON_TIMEOUT;
			end else if (stop_hit) begin
				exit_close  = 1'b1;
				exit_reason = tbpm_pkg::REASON_STOP;
			end else if (take_hit) begin
				exit_close  = 1'b1;
				exit_reason = tbpm_pkg::REASON_TAKE;
			end
		end
	end

	// Entry: open on a signal unless already held that way, reversing if needed
	always_comb begin
		still_held  = holding_q && !exit_close;
		want_signal = is_tick && vol_hit_s1 && (trend.go_long || trend.go_short);
		want_short  = trend.go_short;
		open_now    = want_signal && !(still_held && (short_q == want_short));
		rev_close   = open_now && still_held;
		close_now   = exit_close || rev_close;
		reason_now  = rev_close ? tbpm_pkg::REASON_REVERSE : exit_reason;
		hold_next   = open_now || (holding_q && !close_now);
		short_next  = open_now ? want_short : short_q;
	end

	// Trade profit after fee, saturated, then the saturated balance
	always_comb begin
		if (short_q) begin
			diff_gain = $signed({2'b00, entry_price_q}) - $signed({2'b00, price_s1});
		end else begin
			diff_gain = $signed({2'b00, price_s1}) - $signed({2'b00, entry_price_q});
		end
		gain_raw = (tbpm_pkg::PRICE_W + 3)'(diff_gain)
			- $signed({{(tbpm_pkg::PRICE_W + 3 - tbpm_pkg::DIST_W){1'b0}}, fee_q});
		if (gain_raw[tbpm_pkg::PRICE_W+2:tbpm_pkg::PROFIT_W-1] == '0
			|| gain_raw[tbpm_pkg::PRICE_W+2:tbpm_pkg::PROFIT_W-1] == '1) begin
			gain_sat = gain_raw[tbpm_pkg::PROFIT_W-1:0];
		end else if (gain_raw[tbpm_pkg::PRICE_W+2]) begin
			gain_sat = {1'b1, {(tbpm_pkg::PROFIT_W-1){1'b0}}};
		end else begin
			gain_sat = {1'b0, {(tbpm_pkg::PROFIT_W-1){1'b1}}};
		end
		bal_sum = (tbpm_pkg::BAL_W + 1)'(balance_q) + (tbpm_pkg::BAL_W + 1)'(gain_sat);
		if (bal_sum[tbpm_pkg::BAL_W] == bal_sum[tbpm_pkg::BAL_W-1]) begin
			bal_next = bal_sum[tbpm_pkg::BAL_W-1:0];
		end else if (bal_sum[tbpm_pkg::BAL_W]) begin
			bal_next = {1'b1, {(tbpm_pkg::BAL_W-1){1'b0}}};
		end else begin
			bal_next = {1'b0, {(tbpm_pkg::BAL_W-1){1'b1}}};
		end
	end

	// Bracket levels for a position opened at this price, floored at zero
	always_comb begin
		if (want_short) begin
			stop_open = p32 + tbpm_pkg::LEVEL_W'(stop_dist_q);
			take_open = (price_s1 >= tbpm_pkg::PRICE_W'(take_dist_q))
				? p32 - tbpm_pkg::LEVEL_W'(take_dist_q) : '0;
		end else begin
			stop_open = (price_s1 >= tbpm_pkg::PRICE_W'(stop_dist_q))
				? p32 - tbpm_pkg::LEVEL_W'(stop_dist_q) : '0;
			take_open = p32 + tbpm_pkg::LEVEL_W'(take_dist_q);
		end
	end

	// Update position state as each item leaves stage one; a hold-timeout write re-bases the deadline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q     <= 1'b0;
			short_q       <= 1'b0;
			entry_price_q <= '0;
			entry_time_q  <= '0;
			deadline_q    <= (tbpm_pkg::TIME_W + 1)'(tbpm_pkg::TIMEOUT_RST);
			stop_q        <= '0;
			take_q        <= '0;
			balance_q     <= '0;
		end else if (cfg_wr && (cfg_index == tbpm_pkg::REG_HOLD_TIMEOUT)) begin
			deadline_q <= {1'b0, entry_time_q}
				+ (tbpm_pkg::TIME_W + 1)'(cfg_data[tbpm_pkg::TIMEOUT_W-1:0]);
		end else if (fire1) begin
			holding_q <= hold_next;
			short_q   <= short_next;
			if (close_now) begin
				balance_q <= bal_next;
			end
			if (open_now) begin
				entry_price_q <= price_s1;
				entry_time_q  <= time_s1;
				deadline_q    <= {1'b0, time_s1} + (tbpm_pkg::TIME_W + 1)'(timeout_q);
				stop_q        <= stop_open;
				take_q        <= take_open;
			end
		end
	end

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			closed_q         <= close_now;
			reason_q         <= close_now ? reason_now : tbpm_pkg::REASON_STOP;
			profit_q         <= close_now ? gain_sat : '0;
			opened_q         <= open_now;
			position_open_q  <= hold_next;
			position_short_q <= hold_next && short_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign closed          = closed_q;
	assign close_reason    = reason_q;
	assign trade_profit    = profit_q;
	assign running_balance = balance_q;
	assign opened          = opened_q;
	assign position_open   = position_open_q;
	assign position_short  = position_short_q;

	`TBPM_ASSERT_IMP(a_open_held, out_valid_q && opened_q, position_open_q, "opened without a position")
	`TBPM_ASSERT_IMP(a_reverse_opens, out_valid_q && closed_q && (reason_q == tbpm_pkg::REASON_REVERSE), opened_q, "reverse close without a new position")
	`TBPM_ASSERT_IMP(a_state_matches, out_valid_q, position_open_q == holding_q, "result position differs from held state")
	`TBPM_ASSERT_NXT(a_balance_hold, fire1 && !close_now, $stable(balance_q), "balance moved without a close")
	`TBPM_ASSERT_IMP(a_no_stall_empty, !valid_s1, !in_stall, "input stalled with stage one empty")

endmodule

`default_nettype wire

### bench/tb_tick_bracket_position_manager.sv
`timescale 1ns / 1ps

module tb_tick_bracket_position_manager;

	localparam int     MAX_WINDOW  = 512;
	localparam int     CYCLE_LIMIT = 200000;
	localparam int     SCRIPT_ROWS = 22;
	localparam longint PRICE_TOP   = 64'h7FFF_FFFF;
	localparam longint VOLUME_TOP  = 64'hFFFF_FFFF;
	localparam longint TIME_MASK   = 64'hFF_FFFF_FFFF;
	localparam longint PROFIT_MAX  = 64'sh7FFF_FFFF;
	localparam longint PROFIT_MIN  = -64'sh8000_0000;
	localparam longint BALANCE_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint BALANCE_MIN = -64'sh8000_0000_0000;

	typedef struct packed {
		logic               closed;
		tbpm_pkg::reason_t  reason;
		logic signed [31:0] profit;
		logic signed [47:0] balance;
		logic               opened;
		logic               held;
		logic               short_side;
	} trade_report_t;

	typedef enum logic [1:0] {ROW_TICK, ROW_FINISH, ROW_WRITE} script_kind_t;

	typedef struct packed {
		script_kind_t        kind;
		tbpm_pkg::cfg_reg_t  sel;
		logic [31:0]         data;
		logic [39:0]         stamp;
		logic [30:0]         price;
		logic [31:0]         volume;
		logic                typed;
		trade_report_t       want;
	} script_row_t;

	typedef struct {
		longint stop, take, hold, vol, trend, wlen, fee;
		longint base, span, tstep;
		int     count;
		bit     steady;
	} session_t;

	localparam trade_report_t QUIET = '0;
	localparam trade_report_t OPENED_LONG = '{closed: 1'b0, reason: tbpm_pkg::REASON_STOP,
		profit: 32'sd0, balance: 48'sd0, opened: 1'b1, held: 1'b1, short_side: 1'b0};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic opcode;
	logic [tbpm_pkg::TIME_W-1:0] tick_time;
	logic [tbpm_pkg::PRICE_W-1:0] tick_price;
	logic [tbpm_pkg::VOL_W-1:0] tick_volume;
	logic out_valid;
	logic out_stall = 1'b0;
	logic closed;
	logic [1:0] close_reason;
	logic signed [tbpm_pkg::PROFIT_W-1:0] trade_profit;
	logic signed [tbpm_pkg::BAL_W-1:0] running_balance;
	logic opened;
	logic position_open;
	logic position_short;
	logic cfg_valid;
	logic cfg_ready;
	logic [tbpm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tbpm_pkg::CFG_DATA_W-1:0] cfg_data;

	// predictor copy of the register file
	longint stop_dist  = longint'(tbpm_pkg::STOP_DIST_RST);
	longint take_dist  = longint'(tbpm_pkg::TAKE_DIST_RST);
	longint hold_ms    = longint'(tbpm_pkg::TIMEOUT_RST);
	longint min_volume = longint'(tbpm_pkg::VOL_THR_RST);
	longint flat_band  = longint'(tbpm_pkg::TREND_THR_RST);
	longint window_len = longint'(tbpm_pkg::WLEN_RST);
	longint fee        = longint'(tbpm_pkg::FEE_RST);

	// predictor copy of the price window and the position
	int unsigned recent_prices [MAX_WINDOW];
	longint window_total = 0;
	longint window_count = 0;
	longint window_head  = 0;
	bit     in_position  = 1'b0;
	bit     short_held   = 1'b0;
	longint entry_px     = 0;
	longint entry_ms     = 0;
	longint stop_px      = 0;
	longint take_px      = 0;
	longint pnl_total    = 0;

	trade_report_t reports_due [$];
	script_row_t   script [SCRIPT_ROWS];
	session_t      sessions [6];
	bit            steady_flow = 1'b0;
	int            faults = 0;
	int            cycle_count = 0;

	tick_bracket_position_manager #(.MAX_WINDOW(MAX_WINDOW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.tick_time(tick_time),
		.tick_price(tick_price),
		.tick_volume(tick_volume),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.closed(closed),
		.close_reason(close_reason),
		.trade_profit(trade_profit),
		.running_balance(running_balance),
		.opened(opened),
		.position_open(position_open),
		.position_short(position_short),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Close the held position at exit_px, book the fee-adjusted gain into the balance.
	function automatic longint settle_position(longint exit_px);
		longint gain;
		gain = short_held ? entry_px - exit_px : exit_px - entry_px;
		gain -= fee;
		if (gain > PROFIT_MAX) gain = PROFIT_MAX;
		if (gain < PROFIT_MIN) gain = PROFIT_MIN;
		pnl_total += gain;
		if (pnl_total > BALANCE_MAX) pnl_total = BALANCE_MAX;
		if (pnl_total < BALANCE_MIN) pnl_total = BALANCE_MIN;
		in_position = 1'b0;
		return gain;
	endfunction

	// Work out the result of one item and advance the predictor state.
	function automatic trade_report_t forecast_trade(tbpm_pkg::opcode_t op,
			logic [39:0] stamp, logic [30:0] price, logic [31:0] volume);
		trade_report_t r;
		longint p, t, n, gap, band, gain;
		longint w, slot;
		bit has_signal, go_short;
		r = '0;
		p = longint'(price);
		t = longint'(stamp);
		gain = 0;
		if (op == tbpm_pkg::OP_FINISH) begin
			if (in_position) begin
				r.closed = 1'b1;
				r.reason = tbpm_pkg::REASON_TIMEOUT;
				gain = settle_position(p);
			end
		end else begin
			// exits: timeout first, then stop, then take
			if (in_position) begin
				if (t >= entry_ms + hold_ms) begin
					r.closed = 1'b1;
					r.reason = tbpm_pkg::REASON_TIMEOUT;
				end else if (!short_held) begin
					if (p < stop_px) begin
						r.closed = 1'b1;
						r.reason = tbpm_pkg::REASON_STOP;
					end else if (p > take_px) begin
						r.closed = 1'b1;
						r.reason = tbpm_pkg::REASON_TAKE;
					end
				end else begin
					if (p > stop_px) begin
						r.closed = 1'b1;
						r.reason = tbpm_pkg::REASON_STOP;
					end else if (p < take_px) begin
						r.closed = 1'b1;
						r.reason = tbpm_pkg::REASON_TAKE;
					end
				end
				if (r.closed) gain = settle_position(p);
			end
			// entry: compare price with the window mean, scaled by the count
			if (longint'(volume) > min_volume && window_count > 0) begin
				n = window_count;
				gap = window_total - p * n;
				band = flat_band * n;
				has_signal = 1'b1;
				if ((gap < 0 ? -gap : gap) < band) begin
					has_signal = (gap != 0);
					go_short = (gap > 0);
				end else begin
					go_short = (gap < 0);
				end
				if (has_signal && !(in_position && short_held == go_short)) begin
					if (in_position) begin
						r.closed = 1'b1;
						r.reason = tbpm_pkg::REASON_REVERSE;
						gain = settle_position(p);
					end
					in_position = 1'b1;
					short_held = go_short;
					entry_px = p;
					entry_ms = t;
					if (go_short) begin
						stop_px = p + stop_dist;
						take_px = p >= take_dist ? p - take_dist : 0;
					end else begin
						stop_px = p >= stop_dist ? p - stop_dist : 0;
						take_px = p + take_dist;
					end
					r.opened = 1'b1;
				end
			end
			// push the price into the ring
			w = window_len < 1 ? 1 : (window_len > MAX_WINDOW ? MAX_WINDOW : window_len);
			slot = window_head < w ? window_head : 0;
			if (window_count >= w) window_total -= recent_prices[slot];
			else window_count++;
			recent_prices[slot] = price;
			window_total += p;
			slot++;
			window_head = slot >= w ? 0 : slot;
		end
		if (r.closed) r.profit = gain[31:0];
		r.balance = pnl_total[47:0];
		r.held = in_position;
		r.short_side = in_position && short_held;
		return r;
	endfunction

	// Append one booked result at the tail of the queue.
	task automatic book_report(trade_report_t r);
		reports_due.insert(reports_due.size(), r);
	endtask

	// Offer one item, idling at random first; book its result once the beat is taken.
	task automatic offer_tick(tbpm_pkg::opcode_t op, logic [39:0] stamp, logic [30:0] price,
			logic [31:0] volume, logic typed, trade_report_t given);
		trade_report_t predicted;
		while (!steady_flow && $urandom_range(0, 99) < 33) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		tick_time = stamp;
		tick_price = price;
		tick_volume = volume;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		predicted = forecast_trade(op, stamp, price, volume);
		book_report(typed ? given : predicted);
	endtask

	// Write one register once nothing is in flight.
	task automatic write_register(tbpm_pkg::cfg_reg_t sel, logic [31:0] value);
		in_valid = 1'b0;
		while (reports_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = sel;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		case (sel)
			tbpm_pkg::REG_STOP_DISTANCE: stop_dist = longint'(value[19:0]);
			tbpm_pkg::REG_TAKE_DISTANCE: take_dist = longint'(value[19:0]);
			tbpm_pkg::REG_HOLD_TIMEOUT: hold_ms = longint'(value);
			tbpm_pkg::REG_VOLUME_THRESHOLD: min_volume = longint'(value);
			tbpm_pkg::REG_TREND_THRESHOLD: flat_band = longint'(value[19:0]);
			tbpm_pkg::REG_WINDOW_LENGTH: begin
				window_len = longint'(value[9:0]);
				window_total = 0;
				window_count = 0;
				window_head = 0;
			end
			tbpm_pkg::REG_TRADE_FEE: fee = longint'(value[19:0]);
			default: ;
		endcase
	endtask

	// stall the result side at random, except in the steady stretch
	always @(negedge clk) begin
		out_stall <= !steady_flow && ($urandom_range(0, 99) < 33);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// compare every result beat with the oldest booked result
	always @(posedge clk) begin
		trade_report_t seen, due;
		if (arst_n && out_valid && !out_stall) begin
			seen.closed = closed;
			seen.reason = tbpm_pkg::reason_t'(close_reason);
			seen.profit = trade_profit;
			seen.balance = running_balance;
			seen.opened = opened;
			seen.held = position_open;
			seen.short_side = position_short;
			if (reports_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result beat at cycle %0d", cycle_count);
			end else begin
				due = reports_due.pop_front();
				if (seen.closed !== due.closed || seen.reason !== due.reason
						|| seen.profit !== due.profit || seen.balance !== due.balance
						|| seen.opened !== due.opened || seen.held !== due.held
						|| seen.short_side !== due.short_side) begin
					faults++;
					if (faults <= 10)
						$display({"mismatch at cycle %0d (expected/actual): closed %0d/%0d",
							" reason %0d/%0d profit %0d/%0d balance %0d/%0d",
							" opened %0d/%0d open %0d/%0d short %0d/%0d"},
							cycle_count, due.closed, seen.closed, due.reason, seen.reason,
							due.profit, seen.profit, due.balance, seen.balance,
							due.opened, seen.opened, due.held, seen.held,
							due.short_side, seen.short_side);
				end
			end
		end
	end

	initial begin
		session_t ph;
		longint px, quote, clock_ms, vol;
		tbpm_pkg::opcode_t op;

		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = tbpm_pkg::OP_TICK;
		tick_time = '0;
		tick_price = '0;
		tick_volume = '0;
		cfg_valid = 1'b0;
		cfg_index = tbpm_pkg::REG_STOP_DISTANCE;
		cfg_data = '0;

		// Directed rows run at the reset settings until the two writes near the end.
		script = '{
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd1000, 31'd10000, 32'd500,
				1'b1, QUIET},
			'{ROW_FINISH, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd1001, 31'd0, 32'd0,
				1'b1, QUIET},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd1002, 31'd10000, 32'd500,
				1'b1, QUIET},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd1003, 31'd10005, 32'd500,
				1'b1, OPENED_LONG},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd1004, 31'd10050, 32'd0,
				1'b0, QUIET},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd1005, 31'd10000, 32'd101,
				1'b0, QUIET},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd1006, 31'd9979, 32'd100,
				1'b0, QUIET},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd1007, 31'd30000,
				32'hffff_ffff, 1'b0, QUIET},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd1008, 31'd30021, 32'd0,
				1'b0, QUIET},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd1009, 31'd30000,
				32'hffff_ffff, 1'b0, QUIET},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd1010, 31'd29959, 32'd0,
				1'b0, QUIET},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd1011, 31'd30000,
				32'hffff_ffff, 1'b0, QUIET},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd1012, 31'd0,
				32'hffff_ffff, 1'b0, QUIET},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd1013, 31'd0,
				32'hffff_ffff, 1'b0, QUIET},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd4560012, 31'd0, 32'd0,
				1'b0, QUIET},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd4560013, 31'h7fff_ffff,
				32'hffff_ffff, 1'b0, QUIET},
			'{ROW_FINISH, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd4560014, 31'd0, 32'd0,
				1'b0, QUIET},
			'{ROW_WRITE, tbpm_pkg::REG_TRADE_FEE, 32'd1048575, 40'd0, 31'd0, 32'd0,
				1'b0, QUIET},
			'{ROW_WRITE, tbpm_pkg::REG_WINDOW_LENGTH, 32'd0, 40'd0, 31'd0, 32'd0,
				1'b0, QUIET},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'hff_ffff_fffe, 31'h7fff_ffff,
				32'hffff_ffff, 1'b0, QUIET},
			'{ROW_TICK, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'hff_ffff_ffff, 31'h7fff_fc17,
				32'hffff_ffff, 1'b0, QUIET},
			'{ROW_FINISH, tbpm_pkg::REG_STOP_DISTANCE, 32'd0, 40'd0, 31'd0, 32'd0,
				1'b0, QUIET}
		};

		// stop, take, hold, volume, trend, window, fee, base, span, step, items, steady
		sessions[0] = '{200, 300, 50000, 1000, 50, 8, 5, 500000, 150, 2000, 150, 1'b0};
		sessions[1] = '{0, 0, 1, 0, 0, 1, 0, 1000, 3, 1, 120, 1'b0};
		sessions[2] = '{1048575, 1048575, 64'hffff_ffff, 0, 1048575, 1023, 1048575,
			1073741824, 2000000, 1000, 150, 1'b0};
		sessions[3] = '{50, 80, 100000, 64'hffff_ffff, 20, 16, 0, 20000, 60, 500, 60, 1'b0};
		sessions[4] = '{1000, 1500, 200000, 50000, 300, 512, 100, 2147478647, 800, 5000,
			220, 1'b1};
		sessions[5] = '{5, 5, 30, 10, 2, 2, 1048575, 100, 20, 10, 180, 1'b0};

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// walk the directed table
		for (int i = 0; i < SCRIPT_ROWS; i++) begin
			if (script[i].kind == ROW_WRITE)
				write_register(script[i].sel, script[i].data);
			else
				offer_tick(script[i].kind == ROW_FINISH ? tbpm_pkg::OP_FINISH
					: tbpm_pkg::OP_TICK,
					script[i].stamp, script[i].price, script[i].volume,
					script[i].typed, script[i].want);
		end

		// random sessions: a price walk around a base, mostly above-threshold volume
		for (int s = 0; s < 6; s++) begin
			ph = sessions[s];
			write_register(tbpm_pkg::REG_STOP_DISTANCE, 32'(ph.stop));
			write_register(tbpm_pkg::REG_TAKE_DISTANCE, 32'(ph.take));
			write_register(tbpm_pkg::REG_HOLD_TIMEOUT, 32'(ph.hold));
			write_register(tbpm_pkg::REG_VOLUME_THRESHOLD, 32'(ph.vol));
			write_register(tbpm_pkg::REG_TREND_THRESHOLD, 32'(ph.trend));
			write_register(tbpm_pkg::REG_WINDOW_LENGTH, 32'(ph.wlen));
			write_register(tbpm_pkg::REG_TRADE_FEE, 32'(ph.fee));
			steady_flow = ph.steady;
			px = ph.base;
			clock_ms = (longint'($urandom_range(0, 255)) << 32) | longint'($urandom);
			for (int i = 0; i < ph.count; i++) begin
				// hold off now and then until every result is back
				if ($urandom_range(0, 99) == 0) begin
					in_valid = 1'b0;
					do @(negedge clk); while (reports_due.size() != 0);
				end
				if ($urandom_range(0, 19) == 0) clock_ms += $urandom;
				else clock_ms += $urandom_range(0, 32'(ph.tstep));
				clock_ms &= TIME_MASK;
				px += longint'($urandom_range(0, 32'(2 * ph.span))) - ph.span;
				if (px < 0) px = 0;
				if (px > PRICE_TOP) px = PRICE_TOP;
				quote = ($urandom_range(0, 9) == 0)
					? longint'($urandom_range(0, 32'(PRICE_TOP))) : px;
				if ($urandom_range(0, 9) < 7 && ph.vol < VOLUME_TOP - 1000)
					vol = ph.vol + 1 + $urandom_range(0, 1000);
				else
					vol = longint'($urandom);
				op = ($urandom_range(0, 24) == 0) ? tbpm_pkg::OP_FINISH : tbpm_pkg::OP_TICK;
				offer_tick(op, clock_ms[39:0], quote[30:0], vol[31:0], 1'b0, QUIET);
			end
		end

		// drain and let the pipeline settle
		in_valid = 1'b0;
		steady_flow = 1'b0;
		while (reports_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (faults == 0 && reports_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/tbpm_pkg.sv
rtl/tbpm_ram.sv
rtl/tbpm_window.sv
rtl/tick_bracket_position_manager.sv
bench/tb_tick_bracket_position_manager.sv
